FILE: hw/rtl/wmfp_pkg.sv
// Shared types and constants for the 802.11 management frame parser.
// Depends on nothing; every other file imports it.
package wmfp_pkg;

	// frame storage limit and the position counter widths that follow from it
	localparam int MAX_FRAME_BYTES = 4096;
	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

	// frame control bytes and the channel element id
	localparam logic [7:0] FC_PROBE_REQ  = 8'h40;
	localparam logic [7:0] FC_PROBE_RESP = 8'h50;
	localparam logic [7:0] FC_BEACON     = 8'h80;
	localparam logic [7:0] TAG_DS_PARAM  = 8'h03;

	// byte offsets inside the frame
	localparam logic [POS_W-1:0] OFS_ADDR4_FIRST  = POS_W'(4);
	localparam logic [POS_W-1:0] OFS_ADDR4_LAST   = POS_W'(9);
	localparam logic [POS_W-1:0] OFS_ADDR10_FIRST = POS_W'(10);
	localparam logic [POS_W-1:0] OFS_ADDR10_LAST  = POS_W'(15);
	localparam logic [POS_W-1:0] OFS_TAGS_REQ     = POS_W'(24);
	localparam logic [POS_W-1:0] OFS_TAGS_OTHER   = POS_W'(36);
	localparam logic [POS_W-1:0] OFS_SSID_LEN     = POS_W'(37);
	localparam logic [POS_W-1:0] OFS_SSID_FIRST   = POS_W'(38);

	typedef enum logic [1:0] {
		KIND_REQUEST  = 2'd0,
		KIND_RESPONSE = 2'd1,
		KIND_BEACON   = 2'd2
	} kind_t;

	// tagged element walk: id byte, length byte, first body byte
	typedef enum logic [2:0] {
		TAG_ID   = 3'b001,
		TAG_LEN  = 3'b010,
		TAG_CHAN = 3'b100
	} tag_phase_t;

	typedef struct packed {
		logic        record_kind;
		logic [7:0]  ssid_char;
		logic [1:0]  frame_kind;
		logic [47:0] addr_at_ten;
		logic [47:0] addr_at_four;
		logic [7:0]  ssid_length;
		logic [7:0]  channel;
		logic        channel_found;
		logic        frame_truncated;
	} rec_t;

endpackage

FILE: hw/rtl/wifi_mgmt_frame_parser.sv
// Top level of the 802.11 management frame parser: input register and wiring.
// Depends on wmfp_pkg, wmfp_parse and wmfp_out_reg.
//
// Takes one frame byte per cycle, with frame_end on the last byte, and gives
// SSID characters of probe responses and beacons as they pass, then one
// summary record at frame end (kinds, addresses, SSID length, channel from
// the first DS parameter element, truncation flag). Other frame types give
// nothing. Throughput is one byte per cycle while the output is not stalled.
// A byte's record reaches the result ports through the input register and then
// the result register. The input stalls only while the result register holds a
// record that the sink is stalling, whether or not the held byte makes a record.
// The throughput is set by the per-frame parse state, which is updated once per byte.
// Bytes beyond MAX_FRAME_BYTES are ignored until frame end.
module wifi_mgmt_frame_parser
	import wmfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        record_kind,
	output logic [7:0]  ssid_char,
	output logic [1:0]  frame_kind,
	output logic [47:0] addr_at_ten,
	output logic [47:0] addr_at_four,
	output logic [7:0]  ssid_length,
	output logic [7:0]  channel,
	output logic        channel_found,
	output logic        frame_truncated
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       free;
	logic       step;
	logic       accept;
	logic       rec_hit;
	rec_t       rec;
	rec_t       rec_out;

	// process the held byte whenever the result register can take its record
	assign step     = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	wmfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.end_in  (end_s1),
		.rec_hit (rec_hit),
		.rec     (rec)
	);

	wmfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && rec_hit),
		.rec_in    (rec),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.free      (free),
		.rec_out   (rec_out)
	);

	// spread the record onto its field ports
	assign record_kind     = rec_out.record_kind;
	assign ssid_char       = rec_out.ssid_char;
	assign frame_kind      = rec_out.frame_kind;
	assign addr_at_ten     = rec_out.addr_at_ten;
	assign addr_at_four    = rec_out.addr_at_four;
	assign ssid_length     = rec_out.ssid_length;
	assign channel         = rec_out.channel;
	assign channel_found   = rec_out.channel_found;
	assign frame_truncated = rec_out.frame_truncated;

endmodule

FILE: hw/rtl/wmfp_parse.sv
// Per-frame parse state and the logic that advances it by one byte.
// Depends on wmfp_pkg for offsets, codes and the record type.
module wmfp_parse
	import wmfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  logic       end_in,
	output logic       rec_hit,
	output rec_t       rec
);

	logic [POS_W-1:0] pos_q, pos_d;
	kind_t            kind_q, kind_d;
	logic             known_q, known_d;
	logic [47:0]      addr10_q, addr10_d;
	logic [47:0]      addr4_q, addr4_d;
	logic [7:0]       len_q, len_d;
	logic [POS_W-1:0] ntp_q, ntp_d;
	logic [7:0]       chan_q, chan_d;
	logic             seen_q, seen_d;
	tag_phase_t       phase_q, phase_d;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] ntp_x;
	logic [CMP_W-1:0] ssid_last;
	logic [CMP_W-1:0] tag_next;
	logic [CMP_W-1:0] need;

	// advance the parse state by one byte and form the record it causes
	always_comb begin
		pos_d     = pos_q;
		kind_d    = kind_q;
		known_d   = known_q;
		addr10_d  = addr10_q;
		addr4_d   = addr4_q;
		len_d     = len_q;
		ntp_d     = ntp_q;
		chan_d    = chan_q;
		seen_d    = seen_q;
		phase_d   = phase_q;
		rec_hit   = 1'b0;
		rec       = '0;
		pos_x     = CMP_W'(pos_q);
		ntp_x     = CMP_W'(ntp_q);
		ssid_last = CMP_W'(OFS_SSID_LEN) + CMP_W'(len_q);
		tag_next  = ntp_x + CMP_W'(2) + CMP_W'(byte_in);
		need      = '0;

		if (pos_q < POS_MAX) begin
			if (pos_q == '0) begin
				// classify on the frame control byte
				known_d = 1'b1;
				unique case (byte_in)
					FC_PROBE_REQ: begin
						kind_d = KIND_REQUEST;
						ntp_d  = OFS_TAGS_REQ;
					end
					FC_PROBE_RESP: begin
						kind_d = KIND_RESPONSE;
						ntp_d  = OFS_TAGS_OTHER;
					end
					FC_BEACON: begin
						kind_d = KIND_BEACON;
						ntp_d  = OFS_TAGS_OTHER;
					end
					default: known_d = 1'b0;
				endcase
			end else if (known_q) begin
				// shift in the two addresses, first byte most significant
				if (pos_q >= OFS_ADDR4_FIRST && pos_q <= OFS_ADDR4_LAST)
					addr4_d = {addr4_q[39:0], byte_in};
				if (pos_q >= OFS_ADDR10_FIRST && pos_q <= OFS_ADDR10_LAST)
					addr10_d = {addr10_q[39:0], byte_in};
				if (kind_q != KIND_REQUEST && pos_q == OFS_SSID_LEN)
					len_d = byte_in;
				// stream SSID bytes unless the frame ends here
				if (kind_q != KIND_REQUEST && pos_q >= OFS_SSID_FIRST &&
				    pos_x <= ssid_last && !end_in) begin
					rec_hit          = 1'b1;
					rec.ssid_char    = byte_in;
					rec.frame_kind   = kind_q;
					rec.ssid_length  = len_q;
				end
				// walk the tagged elements until the channel turns up
				if (!seen_q) begin
					unique case (phase_q)
						TAG_ID: begin
							if (pos_q == ntp_q)
								phase_d = (byte_in == TAG_DS_PARAM) ? TAG_CHAN : TAG_LEN;
						end
						TAG_LEN: begin
							if (pos_x == ntp_x + CMP_W'(1)) begin
								if (tag_next >= CMP_W'(MAX_FRAME_BYTES))
									ntp_d = POS_MAX;
								else
									ntp_d = tag_next[POS_W-1:0];
								phase_d = TAG_ID;
							end
						end
						TAG_CHAN: begin
							if (pos_x == ntp_x + CMP_W'(2)) begin
								chan_d = byte_in;
								seen_d = 1'b1;
							end
						end
						default: phase_d = TAG_ID;
					endcase
				end
			end
			pos_d = pos_q + POS_W'(1);
		end

		if (end_in) begin
			// summary from the updated state, then clear for the next frame
			if (known_d) begin
				need = (kind_d == KIND_REQUEST) ? CMP_W'(OFS_ADDR10_LAST)
				                                : CMP_W'(OFS_SSID_LEN) + CMP_W'(len_d);
				rec_hit             = 1'b1;
				rec.record_kind     = 1'b1;
				rec.ssid_char       = 8'd0;
				rec.frame_kind      = kind_d;
				rec.addr_at_ten     = addr10_d;
				rec.addr_at_four    = addr4_d;
				rec.ssid_length     = len_d;
				rec.channel         = seen_d ? chan_d : 8'd0;
				rec.channel_found   = seen_d;
				rec.frame_truncated = (pos_x < need);
			end
			pos_d    = '0;
			kind_d   = KIND_REQUEST;
			known_d  = 1'b0;
			addr10_d = '0;
			addr4_d  = '0;
			len_d    = '0;
			ntp_d    = '0;
			chan_d   = '0;
			seen_d   = 1'b0;
			phase_d  = TAG_ID;
		end
	end

	// hold state between bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			kind_q   <= KIND_REQUEST;
			known_q  <= 1'b0;
			addr10_q <= '0;
			addr4_q  <= '0;
			len_q    <= '0;
			ntp_q    <= '0;
			chan_q   <= '0;
			seen_q   <= 1'b0;
			phase_q  <= TAG_ID;
		end else if (step) begin
			pos_q    <= pos_d;
			kind_q   <= kind_d;
			known_q  <= known_d;
			addr10_q <= addr10_d;
			addr4_q  <= addr4_d;
			len_q    <= len_d;
			ntp_q    <= ntp_d;
			chan_q   <= chan_d;
			seen_q   <= seen_d;
			phase_q  <= phase_d;
		end
	end

endmodule

FILE: hw/rtl/wmfp_out_reg.sv
// Result register of the parser: holds one record until the sink takes it.
// Depends on wmfp_pkg for the record type.
module wmfp_out_reg
	import wmfp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rec_t rec_in,
	input  logic out_stall,
	output logic out_valid,
	output logic free,
	output rec_t rec_out
);

	logic valid_s2;
	rec_t rec_s2;

	// the register can take a new item when empty or being drained
	assign free      = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;
	assign rec_out   = rec_s2;

	// load a new item or drop the one taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_s2 <= rec_in;
		end
	end

endmodule

FILE: tb/tb_wifi_mgmt_frame_parser.sv
// Testbench for wifi_mgmt_frame_parser: streams directed and random 802.11 frames through
// the byte handshake and checks every record against a parser model kept in this file.
// Depends on wmfp_pkg and the parser RTL.
module tb_wifi_mgmt_frame_parser;
	import wmfp_pkg::*;

	localparam int BYTE_BUDGET    = 1650;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam logic [7:0] TAG_SSID = 8'h00;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_octet_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  frame_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        record_kind;
	logic [7:0]  ssid_char;
	logic [1:0]  frame_kind;
	logic [47:0] addr_at_ten;
	logic [47:0] addr_at_four;
	logic [7:0]  ssid_length;
	logic [7:0]  channel;
	logic        channel_found;
	logic        frame_truncated;

	frame_octet_t octets_to_send[$];
	rec_t         expected_records[$];

	int mismatches = 0;
	int frames_sent = 0;
	int bytes_accepted = 0;
	int records_seen = 0;
	int ssid_chars_checked = 0;
	int summaries_checked = 0;

	// per-frame parse state of the model
	logic [POS_W-1:0] cur_pos;
	kind_t            cur_kind;
	logic             kind_known;
	logic [47:0]      addr10_acc;
	logic [47:0]      addr4_acc;
	logic [7:0]       len_byte;
	logic [POS_W-1:0] tag_at;
	tag_phase_t       tag_step;
	logic [7:0]       chan_val;
	logic             chan_seen;

	// idle control for both sides
	int  send_gap = 0;
	int  stall_left = 0;
	bit  send_quiet = 1'b0;
	bit  recv_quiet = 1'b0;
	int  idle_cycles = 0;
	rec_t seen;

	wifi_mgmt_frame_parser DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.frame_byte      (frame_byte),
		.frame_end       (frame_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.record_kind     (record_kind),
		.ssid_char       (ssid_char),
		.frame_kind      (frame_kind),
		.addr_at_ten     (addr_at_ten),
		.addr_at_four    (addr_at_four),
		.ssid_length     (ssid_length),
		.channel         (channel),
		.channel_found   (channel_found),
		.frame_truncated (frame_truncated)
	);

	always #6 clk = ~clk;

	// clear all per-frame state
	function automatic void clear_parse();
		cur_pos    = '0;
		cur_kind   = KIND_REQUEST;
		kind_known = 1'b0;
		addr10_acc = '0;
		addr4_acc  = '0;
		len_byte   = '0;
		tag_at     = '0;
		tag_step   = TAG_ID;
		chan_val   = '0;
		chan_seen  = 1'b0;
	endfunction

	// advance the parse by one accepted byte and queue the record it causes
	function automatic void parse_byte(input logic [7:0] b, input logic last);
		int   p;
		int   need;
		int   nxt;
		rec_t r;
		p = int'(cur_pos);
		if (p < MAX_FRAME_BYTES) begin
			if (p == 0) begin
				kind_known = 1'b1;
				case (b)
					FC_PROBE_REQ: begin
						cur_kind = KIND_REQUEST;
						tag_at   = OFS_TAGS_REQ;
					end
					FC_PROBE_RESP: begin
						cur_kind = KIND_RESPONSE;
						tag_at   = OFS_TAGS_OTHER;
					end
					FC_BEACON: begin
						cur_kind = KIND_BEACON;
						tag_at   = OFS_TAGS_OTHER;
					end
					default: kind_known = 1'b0;
				endcase
			end else if (kind_known) begin
				if (p >= 4 && p <= 9)
					addr4_acc = {addr4_acc[39:0], b};
				if (p >= 10 && p <= 15)
					addr10_acc = {addr10_acc[39:0], b};
				if (cur_kind != KIND_REQUEST && p == 37)
					len_byte = b;
				// stream SSID characters unless this byte ends the frame
				if (cur_kind != KIND_REQUEST && p >= 38 && p <= 37 + int'(len_byte)
						&& !last) begin
					r = '0;
					r.ssid_char   = b;
					r.frame_kind  = cur_kind;
					r.ssid_length = len_byte;
					expected_records.push_back(r);
				end
				// walk tagged elements until the channel element body
				if (!chan_seen) begin
					case (tag_step)
						TAG_ID: begin
							if (p == int'(tag_at))
								tag_step = (b == TAG_DS_PARAM) ? TAG_CHAN : TAG_LEN;
						end
						TAG_LEN: begin
							if (p == int'(tag_at) + 1) begin
								nxt = int'(tag_at) + 2 + int'(b);
								tag_at = (nxt >= MAX_FRAME_BYTES) ? POS_MAX : POS_W'(nxt);
								tag_step = TAG_ID;
							end
						end
						TAG_CHAN: begin
							if (p == int'(tag_at) + 2) begin
								chan_val  = b;
								chan_seen = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			cur_pos = POS_W'(p + 1);
		end
		if (last) begin
			if (kind_known) begin
				need = (cur_kind == KIND_REQUEST) ? 15 : 37 + int'(len_byte);
				r = '0;
				r.record_kind     = 1'b1;
				r.frame_kind      = cur_kind;
				r.addr_at_ten     = addr10_acc;
				r.addr_at_four    = addr4_acc;
				r.ssid_length     = len_byte;
				r.channel         = chan_seen ? chan_val : 8'h00;
				r.channel_found   = chan_seen;
				r.frame_truncated = (p < need);
				expected_records.push_back(r);
			end
			clear_parse();
		end
	endfunction

	// idle length: mostly none, some short, a few long; none at all in quiet stretches
	function automatic int pick_idle(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// queue a frame, marking its last byte
	task automatic send_frame(input logic [7:0] f[$]);
		int k;
		for (k = 0; k < f.size(); k++)
			octets_to_send.push_back('{data: f[k], last: (k == f.size() - 1)});
		frames_sent++;
	endtask

	// frame with the given first byte and random content
	task automatic build_raw(input logic [7:0] fc, input int len);
		logic [7:0] f[$];
		int         k;
		f.push_back(fc);
		for (k = 1; k < len; k++)
			f.push_back(8'($urandom));
		send_frame(f);
	endtask

	// well-formed management frame: header, SSID element, more elements, optional cut or pad
	task automatic build_mgmt(input logic [7:0] fc, input int min_len, input bit with_chan);
		logic [7:0] f[$];
		int         hdr;
		int         slen;
		int         n_el;
		int         chan_el;
		int         el_len;
		int         crit;
		int         keep;
		int         id;
		int         i;
		int         k;
		f.push_back(fc);
		hdr = (fc == FC_PROBE_REQ) ? int'(OFS_TAGS_REQ) : int'(OFS_TAGS_OTHER);
		for (k = 1; k < hdr; k++)
			f.push_back(8'($urandom));
		slen = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 255) : $urandom_range(0, 32);
		if (min_len > 0)
			slen = 255;
		// now and then the first element is the channel element itself
		f.push_back((with_chan && $urandom_range(0, 9) == 0) ? TAG_DS_PARAM : TAG_SSID);
		f.push_back(8'(slen));
		for (k = 0; k < slen; k++)
			f.push_back(8'($urandom));
		n_el = $urandom_range(0, 3);
		chan_el = with_chan ? $urandom_range(0, n_el) : -1;
		for (i = 0; i <= n_el || f.size() < min_len; i++) begin
			if (i == chan_el) begin
				el_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 1;
				f.push_back(TAG_DS_PARAM);
			end else begin
				id = $urandom_range(0, 254);
				if (id >= 3)
					id++;
				el_len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) :
					$urandom_range(0, 12);
				if (min_len > 0)
					el_len = 255;
				f.push_back(8'(id));
			end
			f.push_back(8'(el_len));
			for (k = 0; k < el_len; k++)
				f.push_back(8'($urandom));
		end
		// cut short, end right at or just before the last needed byte, or pad
		if (min_len == 0) begin
			crit = (fc == FC_PROBE_REQ) ? 16 : 38 + slen;
			keep = f.size();
			case ($urandom_range(0, 9))
				5: repeat ($urandom_range(1, 6)) f.push_back(8'($urandom));
				6, 7: keep = $urandom_range(1, f.size());
				8: if (crit <= f.size()) keep = crit;
				9: if (crit - 1 <= f.size()) keep = crit - 1;
				default: ;
			endcase
			while (f.size() > keep)
				void'(f.pop_back());
		end
		send_frame(f);
	endtask

	// log one mismatch and count it
	task automatic report_mismatch(input string field, input logic [47:0] got,
			input logic [47:0] want);
		$display("mismatch in record %0d, %s: got %0h, expected %0h",
			records_seen, field, got, want);
		mismatches++;
	endtask

	// compare one accepted record with the oldest expectation
	task automatic check_record(input rec_t got);
		rec_t want;
		if (expected_records.size() == 0) begin
			report_mismatch("record with none expected", 48'(got.record_kind), 48'h0);
		end else begin
			want = expected_records.pop_front();
			if (got.record_kind !== want.record_kind)
				report_mismatch("record_kind", 48'(got.record_kind), 48'(want.record_kind));
			if (got.ssid_char !== want.ssid_char)
				report_mismatch("ssid_char", 48'(got.ssid_char), 48'(want.ssid_char));
			if (got.frame_kind !== want.frame_kind)
				report_mismatch("frame_kind", 48'(got.frame_kind), 48'(want.frame_kind));
			if (got.addr_at_ten !== want.addr_at_ten)
				report_mismatch("addr_at_ten", got.addr_at_ten, want.addr_at_ten);
			if (got.addr_at_four !== want.addr_at_four)
				report_mismatch("addr_at_four", got.addr_at_four, want.addr_at_four);
			if (got.ssid_length !== want.ssid_length)
				report_mismatch("ssid_length", 48'(got.ssid_length), 48'(want.ssid_length));
			if (got.channel !== want.channel)
				report_mismatch("channel", 48'(got.channel), 48'(want.channel));
			if (got.channel_found !== want.channel_found)
				report_mismatch("channel_found", 48'(got.channel_found),
					48'(want.channel_found));
			if (got.frame_truncated !== want.frame_truncated)
				report_mismatch("frame_truncated", 48'(got.frame_truncated),
					48'(want.frame_truncated));
			if (want.record_kind)
				summaries_checked++;
			else
				ssid_chars_checked++;
		end
		records_seen++;
	endtask

	// driver: predict on acceptance, then present the next item or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			clear_parse();
		end else begin
			if (in_valid && !in_stall) begin
				parse_byte(frame_byte, frame_end);
				bytes_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if ($urandom_range(0, 149) == 0)
					send_quiet = !send_quiet;
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (octets_to_send.size() > 0) begin
					in_valid   <= 1'b1;
					frame_byte <= octets_to_send[0].data;
					frame_end  <= octets_to_send[0].last;
					void'(octets_to_send.pop_front());
					send_gap = pick_idle(send_quiet);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check accepted records, stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {record_kind, ssid_char, frame_kind, addr_at_ten, addr_at_four,
					ssid_length, channel, channel_found, frame_truncated};
				check_record(seen);
			end
			if ($urandom_range(0, 149) == 0)
				recv_quiet = !recv_quiet;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_idle(recv_quiet);
			end
		end
	end

	// watchdog: end the run when no handshake completes for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d records still expected",
				idle_cycles, expected_records.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [7:0] f[$];
		logic [7:0] fc;
		int         k;
		int         r;

		// one-byte frames of every kind, plus other kinds
		build_raw(FC_PROBE_REQ, 1);
		build_raw(FC_PROBE_RESP, 1);
		build_raw(FC_BEACON, 1);
		build_raw(8'h00, 1);
		build_raw(8'hFF, 1);
		// request ending on its last address byte: all-ones and all-zeros addresses
		f.push_back(FC_PROBE_REQ);
		for (k = 1; k < 16; k++)
			f.push_back((k >= 4 && k <= 9) ? 8'hFF : 8'h00);
		send_frame(f);
		build_raw(8'h10, 3);

		// random frames, mostly well formed
		while (octets_to_send.size() < BYTE_BUDGET) begin
			r = $urandom_range(0, 19);
			if (r < 15) begin
				case ($urandom_range(0, 2))
					0: fc = FC_PROBE_REQ;
					1: fc = FC_PROBE_RESP;
					default: fc = FC_BEACON;
				endcase
				build_mgmt(fc, 0, $urandom_range(0, 4) != 0);
			end else if (r < 18) begin
				do
					fc = 8'($urandom);
				while (fc == FC_PROBE_REQ || fc == FC_PROBE_RESP || fc == FC_BEACON);
				build_raw(fc, $urandom_range(1, 60));
			end else begin
				fc = ($urandom_range(0, 1) == 0) ? FC_PROBE_RESP : FC_PROBE_REQ;
				build_raw(fc, $urandom_range(1, 80));
			end
		end

		// hold reset, then release away from the clock edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all bytes sent and every expected record received
		do
			@(negedge clk);
		while (octets_to_send.size() != 0 || in_valid || expected_records.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d frames of every kind, whole, cut short and padded, %0d bytes accepted",
			frames_sent, bytes_accepted);
		$display("%0d SSID characters and %0d frame summaries checked, %0d mismatches",
			ssid_chars_checked, summaries_checked, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
